[sv/text_console_writer_unit_assert.svh]
// ----------------------------------------------------------------------------
// text console writer assertion macros
// shared concurrent assertion forms, sampled on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// condition must hold at every edge out of reset
`define TCW_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// same-cycle implication
`define TCW_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// shared types and constants of the text console writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_BLANK   = 8'h20;
  localparam logic [7:0] ATTR_RESET   = 8'h0F;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_BLANK,
    ST_EMIT
  } tcw_state_e;

endpackage

[sv/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/text_console_writer_unit.sv]
// ----------------------------------------------------------------------------
// text_console_writer_unit
// a put without scroll, a read or opcode 3 goes straight to ST_EMIT, where the
// result beat is registered once the output is free; a put that scrolls first copies
// the screen up one row and blanks the last row, a clear first blanks every cell,
// one cell per cycle; one item at a time, a new item is accepted only in ST_IDLE
// reset: a clearing pass (ST_INIT) fills every cell with blanks with attribute 0x0F,
// no item is accepted during it, attribute writes are taken as usual
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_console_writer_unit
  import tcw_pkg::*;
#(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS = 25,
  localparam int unsigned CELLS = COLUMNS * ROWS,
  localparam int unsigned AW = $clog2(CELLS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          text_attr_we_i,
  input  logic [7:0]    text_attr_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [1:0]    opcode_i,
  input  logic [7:0]    char_code_i,
  input  logic [AW-1:0] cell_index_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    cell_char_o,
  output logic [7:0]    cell_attr_o,
  output logic [AW-1:0] cursor_o,
  output logic          scrolled_o
);

  `include "text_console_writer_unit_assert.svh"

  localparam int unsigned AW1 = $clog2(CELLS + 1);
  localparam int unsigned CW = $clog2(COLUMNS);
  localparam logic [AW1-1:0] COLS_W = AW1'(COLUMNS);
  localparam logic [AW1-1:0] CELLS_W = AW1'(CELLS);
  localparam logic [AW1-1:0] LAST_ROW_W = AW1'(CELLS - COLUMNS);
  localparam logic [CW-1:0] COL_LAST = CW'(COLUMNS - 1);

  tcw_state_e state_q, state_d;

  logic [AW1-1:0] ptr_q, ptr_d;
  logic           cp_v_q, cp_v_d;
  logic [AW-1:0]  cp_waddr_q;
  logic [AW-1:0]  cursor_q, cursor_d;
  logic [CW-1:0]  col_q, col_d;
  logic [AW1-1:0] row_base_q, row_base_d;
  logic           rd_ok_q, rd_ok_d;
  logic           scr_q, scr_d;
  logic [7:0]     text_attr_q;

  logic          out_valid_q;
  logic [7:0]    cell_char_q, cell_attr_q;
  logic [AW-1:0] cursor_out_q;
  logic          scrolled_q;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0]   ram_wdata, ram_rdata;

  logic           accept, out_load;
  logic           is_nl, step_row, wrap, idx_ok;
  logic [AW1-1:0] next_base;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  assign is_nl     = (char_code_i == CHAR_NEWLINE);
  assign step_row  = is_nl || (col_q == COL_LAST);
  assign next_base = row_base_q + COLS_W;
  assign wrap      = step_row && (next_base == CELLS_W);
  assign idx_ok    = (AW1'(cell_index_i) < CELLS_W);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (ptr_q == CELLS_W - AW1'(1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority if (opcode_i == OP_PUT && wrap) state_d = ST_SCROLL;
          else if (opcode_i == OP_CLEAR)           state_d = ST_BLANK;
          else                                     state_d = ST_EMIT;
        end
      end
      ST_SCROLL: begin
        if (ptr_q == CELLS_W) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (ptr_q == CELLS_W - AW1'(1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // cursor, pass pointer and result flags
  always_comb begin
    ptr_d      = ptr_q;
    cp_v_d     = 1'b0;
    cursor_d   = cursor_q;
    col_d      = col_q;
    row_base_d = row_base_q;
    rd_ok_d    = rd_ok_q;
    scr_d      = scr_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          rd_ok_d = (opcode_i == OP_READ) && idx_ok;
          scr_d   = 1'b0;
          if (opcode_i == OP_PUT) begin
            if (wrap) begin
              ptr_d      = COLS_W;
              scr_d      = 1'b1;
              cursor_d   = LAST_ROW_W[AW-1:0];
              row_base_d = LAST_ROW_W;
              col_d      = '0;
            end else if (step_row) begin
              cursor_d   = next_base[AW-1:0];
              row_base_d = next_base;
              col_d      = '0;
            end else begin
              cursor_d = cursor_q + AW'(1);
              col_d    = col_q + CW'(1);
            end
          end else if (opcode_i == OP_CLEAR) begin
            ptr_d = '0;
          end
        end
      end
      ST_SCROLL: begin
        if (ptr_q != CELLS_W) begin
          ptr_d  = ptr_q + AW1'(1);
          cp_v_d = 1'b1;
        end else begin
          ptr_d = LAST_ROW_W;
        end
      end
      ST_INIT, ST_BLANK: begin
        ptr_d = ptr_q + AW1'(1);
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  // screen ram access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ptr_q[AW-1:0];
    ram_wdata = {text_attr_q, CHAR_BLANK};
    ram_re    = 1'b0;
    ram_raddr = cell_index_i;
    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {ATTR_RESET, CHAR_BLANK};
      end
      ST_BLANK: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        if (accept && opcode_i == OP_PUT && !is_nl) begin
          ram_we    = 1'b1;
          ram_waddr = cursor_q;
          ram_wdata = {text_attr_q, char_code_i};
        end
        ram_re = accept && (opcode_i == OP_READ) && idx_ok;
      end
      ST_SCROLL: begin
        ram_re    = (ptr_q != CELLS_W);
        ram_raddr = ptr_q[AW-1:0];
        ram_we    = cp_v_q;
        ram_waddr = cp_waddr_q;
        ram_wdata = ram_rdata;
      end
      ST_EMIT: begin
      end
      default: begin
      end
    endcase
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      cp_v_q      <= 1'b0;
      cursor_q    <= '0;
      col_q       <= '0;
      row_base_q  <= '0;
      rd_ok_q     <= 1'b0;
      scr_q       <= 1'b0;
      text_attr_q <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      cp_v_q     <= cp_v_d;
      cursor_q   <= cursor_d;
      col_q      <= col_d;
      row_base_q <= row_base_d;
      rd_ok_q    <= rd_ok_d;
      scr_q      <= scr_d;
      if (text_attr_we_i) begin
        text_attr_q <= text_attr_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // copy target address and result beat payload
  always_ff @(posedge clk_i) begin
    cp_waddr_q <= AW'(ptr_q - COLS_W);
    if (out_load) begin
      cell_char_q  <= rd_ok_q ? ram_rdata[7:0] : 8'h00;
      cell_attr_q  <= rd_ok_q ? ram_rdata[15:8] : 8'h00;
      cursor_out_q <= cursor_q;
      scrolled_q   <= scr_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cell_char_o = cell_char_q;
  assign cell_attr_o = cell_attr_q;
  assign cursor_o    = cursor_out_q;
  assign scrolled_o  = scrolled_q;

  `TCW_ASSERT_ALWAYS(a_cursor_range, AW1'(cursor_q) < CELLS_W, "cursor out of range")
  `TCW_ASSERT_NEXT(a_accept_busy, accept, state_q != ST_IDLE, "idle right after accept")
  `TCW_ASSERT_IMPLY(a_scroll_cursor, out_valid_o && scrolled_o, cursor_o == LAST_ROW_W[AW-1:0], "scroll beat cursor not on last row")
  `TCW_ASSERT_IMPLY(a_idle_write, ram_we && state_q == ST_IDLE, accept && opcode_i == OP_PUT && !is_nl, "stray write while idle")

endmodule
